/* sv/echo_distance_bar_graph_defines.svh */
// Assertion macros shared by the bar graph modules
`ifndef ECHO_DISTANCE_BAR_GRAPH_DEFINES_SVH
`define ECHO_DISTANCE_BAR_GRAPH_DEFINES_SVH

// Check on every clock edge outside reset
`define EDBG_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error(msg);

// Check that also holds across reset
`define EDBG_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) \
    else $error(msg);

`endif

/* sv/edbg_pkg.sv */
// Shared widths, register codes and the job type of the echo distance bar graph
package edbg_pkg;

  localparam int CM_W      = 9;
  localparam int CNT_W     = 4;
  localparam int WIDTH_W   = 16;
  localparam int MAXD_W    = 19;
  localparam int D_W       = 21;
  localparam int NUM_W     = MAXD_W + CNT_W;
  localparam int PROD_W    = MAXD_W + 8;
  localparam int BRT_W     = 8;
  localparam int IDX_W     = 3;
  localparam int CFG_IDX_W = 4;
  localparam int CFG_DAT_W = 9;

  localparam int MAX_LEDS_DEF = 8;

  localparam int CM_TO_MILLI  = 1000;
  localparam int MILLI_PER_US = 17;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = 1;
  localparam int QCNT_W      = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_MAX_DISTANCE = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LED_COUNT    = 4'd1;

  localparam logic [CM_W-1:0]  MAX_DIST_RST  = 9'd25;
  localparam logic [CNT_W-1:0] LED_COUNT_RST = 4'd7;

  localparam logic [BRT_W-1:0] FULL_ON = 8'hFF;

  typedef struct packed {
    logic [MAXD_W-1:0] maxd;
    logic [NUM_W-1:0]  num;
    logic [CNT_W-1:0]  n;
  } edbg_job_t;

endpackage

/* sv/edbg_front.sv */
// Front part: accepts echo widths and forms the scaled bar level numerator
module edbg_front #(
  parameter int MAX_LEDS = edbg_pkg::MAX_LEDS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         echo_valid,
  output logic                         echo_stall,
  input  logic [edbg_pkg::WIDTH_W-1:0] echo_width_us,
  input  logic [edbg_pkg::CM_W-1:0]    max_distance_cm,
  input  logic [edbg_pkg::CNT_W-1:0]   led_count,
  output logic                         job_valid,
  output edbg_pkg::edbg_job_t          job,
  input  logic                         job_full
);
  import edbg_pkg::*;

  logic              a_valid;
  logic [D_W-1:0]    a_d;
  logic [MAXD_W-1:0] a_maxd;
  logic [CNT_W-1:0]  a_n;
  logic              b_valid;
  edbg_job_t         b_job;

  logic              a_move;
  logic              b_move;
  logic [CM_W-1:0]   cm_eff;
  logic [CNT_W-1:0]  n_eff;
  logic [MAXD_W-1:0] d_clamp;
  logic [MAXD_W-1:0] gap;

  assign b_move     = !b_valid || !job_full;
  assign a_move     = !a_valid || b_move;
  assign echo_stall = a_valid && !b_move;
  assign job_valid  = b_valid;
  assign job        = b_job;

  always_comb begin
    cm_eff = (max_distance_cm == '0) ? CM_W'(1) : max_distance_cm;
    if (led_count == '0) begin
      n_eff = CNT_W'(1);
    end else if ({1'b0, led_count} > (CNT_W + 1)'(MAX_LEDS)) begin
      n_eff = CNT_W'(MAX_LEDS);
    end else begin
      n_eff = led_count;
    end
  end

  // timeout and out-of-range echoes sit at full scale
  always_comb begin
    if (a_d == '0 || a_d > D_W'(a_maxd)) begin
      d_clamp = a_maxd;
    end else begin
      d_clamp = a_d[MAXD_W-1:0];
    end
    gap = a_maxd - d_clamp;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      b_valid <= 1'b0;
    end else begin
      if (a_move) begin
        a_valid <= echo_valid;
      end
      if (b_move) begin
        b_valid <= a_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (a_move && echo_valid) begin
      a_d    <= D_W'(echo_width_us) * D_W'(MILLI_PER_US);
      a_maxd <= MAXD_W'(cm_eff) * MAXD_W'(CM_TO_MILLI);
      a_n    <= n_eff;
    end
    if (b_move && a_valid) begin
      b_job.maxd <= a_maxd;
      b_job.num  <= NUM_W'(a_n) * NUM_W'(gap);
      b_job.n    <= a_n;
    end
  end

endmodule

/* sv/edbg_queue.sv */
// Two-entry job queue between the front and back parts
`include "echo_distance_bar_graph_defines.svh"

module edbg_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  edbg_pkg::edbg_job_t data_in,
  output logic                full,
  input  logic                pop,
  output edbg_pkg::edbg_job_t data_out,
  output logic                empty
);
  import edbg_pkg::*;

  edbg_job_t         slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign full     = (count == QCNT_W'(QUEUE_DEPTH));
  assign empty    = (count == '0);
  assign data_out = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + QCNT_W'(1);
      end else if (pop && !push) begin
        count <= count - QCNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= data_in;
    end
  end

  `EDBG_ASSERT(a_no_push_full, push |-> !full, "push into full queue")
  `EDBG_ASSERT(a_no_pop_empty, pop |-> !empty, "pop from empty queue")
  `EDBG_ASSERT(a_count_bound, count <= QCNT_W'(QUEUE_DEPTH), "queue count overflow")
  `EDBG_ASSERT(a_count_step, (push && !pop) |=> (count == $past(count) + QCNT_W'(1)), "queue count did not advance")

endmodule

/* sv/edbg_back.sv */
// Back part: shared restoring divider and per-LED brightness sequencer
`include "echo_distance_bar_graph_defines.svh"

module edbg_back #(
  parameter int MAX_LEDS = edbg_pkg::MAX_LEDS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  edbg_pkg::edbg_job_t        job,
  input  logic                       job_empty,
  output logic                       job_pop,
  output logic                       led_valid,
  input  logic                       led_stall,
  output logic [edbg_pkg::IDX_W-1:0] led_index,
  output logic [edbg_pkg::BRT_W-1:0] brightness,
  output logic                       last
);
  import edbg_pkg::*;

  localparam int QW = (MAX_LEDS > 1) ? $clog2(MAX_LEDS) : 1;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_QUOT  = 3'd1;
  localparam logic [2:0] ST_SCALE = 3'd2;
  localparam logic [2:0] ST_FRAC  = 3'd3;
  localparam logic [2:0] ST_EMIT  = 3'd4;

  logic [2:0]        state;
  logic [PROD_W-1:0] rem;
  logic [MAXD_W-1:0] maxd;
  logic [CNT_W-1:0]  n;
  logic [QW-1:0]     q;
  logic [BRT_W-1:0]  part;
  logic [2:0]        k;
  logic [CNT_W-1:0]  i;

  logic [PROD_W-1:0] div_shift;
  logic              ge;
  logic              out_free;
  logic              at_last;
  logic [BRT_W-1:0]  brt_next;

  assign div_shift = PROD_W'(maxd) << k;
  assign ge        = (rem >= div_shift);
  assign out_free  = !led_valid || !led_stall;
  assign at_last   = (i == n - CNT_W'(1));
  assign job_pop   = (state == ST_IDLE) && !job_empty;

  always_comb begin
    if (i < CNT_W'(q)) begin
      brt_next = FULL_ON;
    end else if (i == CNT_W'(q)) begin
      brt_next = part;
    end else begin
      brt_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      led_valid <= 1'b0;
    end else begin
      // raise on a new LED, hold while stalled, drop once taken
      led_valid <= ((state == ST_EMIT) && out_free) || (led_valid && led_stall);
      case (state)
        ST_IDLE: begin
          if (!job_empty) begin
            state <= ST_QUOT;
          end
        end
        ST_QUOT: begin
          if (k == '0) begin
            state <= ST_SCALE;
          end
        end
        ST_SCALE: begin
          state <= ST_FRAC;
        end
        ST_FRAC: begin
          if (k == '0) begin
            state <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (out_free && at_last) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (!job_empty) begin
          rem  <= PROD_W'(job.num);
          maxd <= job.maxd;
          n    <= job.n;
          q    <= '0;
          k    <= 3'(QW - 1);
        end
      end
      ST_QUOT: begin
        // one quotient bit per cycle, divisor shifted down each step
        if (ge) begin
          rem <= rem - div_shift;
        end
        q <= QW'({q, ge});
        k <= k - 3'd1;
      end
      ST_SCALE: begin
        rem  <= (rem << 8) - rem;
        part <= '0;
        k    <= 3'd7;
      end
      ST_FRAC: begin
        if (ge) begin
          rem <= rem - div_shift;
        end
        part <= {part[BRT_W-2:0], ge};
        k    <= k - 3'd1;
        i    <= '0;
      end
      ST_EMIT: begin
        if (out_free) begin
          led_index  <= i[IDX_W-1:0];
          brightness <= brt_next;
          last       <= at_last;
          i          <= i + CNT_W'(1);
        end
      end
      default: begin
        k <= '0;
      end
    endcase
  end

  `EDBG_ASSERT(a_q_below_n, (state == ST_EMIT) |-> (CNT_W'(q) < n), "bar level reached LED count")
  `EDBG_ASSERT(a_load_nonzero, job_pop |-> (job.n != '0), "job with zero LEDs")
  `EDBG_ASSERT(a_last_closes, (state == ST_EMIT && out_free && at_last) |=> (state == ST_IDLE && led_valid && last), "final LED did not close the measurement")
  `EDBG_ASSERT_RST(a_rst_clears, rst |=> (!led_valid && state == ST_IDLE), "reset left output pending")

endmodule

/* sv/echo_distance_bar_graph.sv */
// Ultrasonic echo width to LED bar graph brightness sequence
//
// Echo channel: echo_valid/echo_stall carry one echo_width_us per
// transaction; a zero width means timeout and lights nothing.
// LED channel: led_valid/led_stall carry one brightness per driven LED,
// led_index 0 first, with last set on the final LED of the measurement.
// Config channel: cfg_valid/cfg_ready write max_distance_cm (index 0) or
// led_count (index 1); cfg_ready is always high. Write only while idle.
// The back part works on one measurement at a time, paced by the single
// shared restoring divider, one quotient bit per cycle, and by the n
// driven LEDs that it emits in turn.
// A two-entry queue lets the front part keep taking echoes while the
// back part divides or waits on a stalled LED channel.
// Reset clears all pending work and returns max_distance_cm to 25 and
// led_count to 7. A stalled LED transaction holds its payload; once the
// queue and both front stages fill, echo_stall rises.
module echo_distance_bar_graph #(
  parameter int MAX_LEDS = edbg_pkg::MAX_LEDS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           echo_valid,
  output logic                           echo_stall,
  input  logic [edbg_pkg::WIDTH_W-1:0]   echo_width_us,
  output logic                           led_valid,
  input  logic                           led_stall,
  output logic [edbg_pkg::IDX_W-1:0]     led_index,
  output logic [edbg_pkg::BRT_W-1:0]     brightness,
  output logic                           last,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [edbg_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [edbg_pkg::CFG_DAT_W-1:0] cfg_data
);
  import edbg_pkg::*;

  logic [CM_W-1:0]  max_distance_cm;
  logic [CNT_W-1:0] led_count;

  logic      q_push;
  logic      q_full;
  logic      q_pop;
  logic      q_empty;
  edbg_job_t front_job;
  edbg_job_t back_job;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_distance_cm <= MAX_DIST_RST;
      led_count       <= LED_COUNT_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_MAX_DISTANCE: max_distance_cm <= cfg_data[CM_W-1:0];
        CFG_LED_COUNT:    led_count       <= cfg_data[CNT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  edbg_front #(
    .MAX_LEDS(MAX_LEDS)
  ) u_front (
    .clk            (clk),
    .rst            (rst),
    .echo_valid     (echo_valid),
    .echo_stall     (echo_stall),
    .echo_width_us  (echo_width_us),
    .max_distance_cm(max_distance_cm),
    .led_count      (led_count),
    .job_valid      (q_push),
    .job            (front_job),
    .job_full       (q_full)
  );

  edbg_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (q_push && !q_full),
    .data_in (front_job),
    .full    (q_full),
    .pop     (q_pop),
    .data_out(back_job),
    .empty   (q_empty)
  );

  edbg_back #(
    .MAX_LEDS(MAX_LEDS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .job       (back_job),
    .job_empty (q_empty),
    .job_pop   (q_pop),
    .led_valid (led_valid),
    .led_stall (led_stall),
    .led_index (led_index),
    .brightness(brightness),
    .last      (last)
  );

endmodule
